// ===== sv/cmdws_pkg.sv =====
// shared types and constants of the command line word splitter
`default_nettype none

package cmdws_pkg;

    // characters the parser looks for
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_DQUOTE  = 8'h22;
    localparam logic [7:0] CH_SQUOTE  = 8'h27;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_LBRACE  = 8'h7B;
    localparam logic [7:0] CH_RBRACE  = 8'h7D;
    localparam logic [7:0] CH_BSLASH  = 8'h5C;

    localparam logic [3:0] MAX_NEST = 4'd15;

    // parse modes
    localparam logic [1:0] MODE_IDLE  = 2'd0;
    localparam logic [1:0] MODE_WORD  = 2'd1;
    localparam logic [1:0] MODE_QUOTE = 2'd2;
    localparam logic [1:0] MODE_VAR   = 2'd3;

    // result kinds
    localparam logic [1:0] KIND_DATA   = 2'd0;
    localparam logic [1:0] KIND_WEND   = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    // status codes
    localparam logic [2:0] ST_OK           = 3'd0;
    localparam logic [2:0] ST_TOO_LONG     = 3'd1;
    localparam logic [2:0] ST_FINAL_BSLASH = 3'd2;
    localparam logic [2:0] ST_NO_SPACE     = 3'd3;
    localparam logic [2:0] ST_BAD_STRING   = 3'd4;
    localparam logic [2:0] ST_BAD_VAR      = 3'd5;
    localparam logic [2:0] ST_EMPTY        = 3'd6;
    localparam logic [2:0] ST_TOO_DEEP     = 3'd7;

    // configuration register indexes
    localparam logic REG_BUF_LEN   = 1'b0;
    localparam logic REG_MAX_WORDS = 1'b1;

    // reset values of the derived limits (buffer 1024, 32 word slots)
    localparam logic [15:0] LEN_LIMIT_RESET  = 16'd1023;
    localparam logic [5:0]  WORD_LIMIT_RESET = 6'd31;

    // per-word operations before space and stop checks
    localparam logic [1:0] OP_DATA = 2'd0;
    localparam logic [1:0] OP_WEND = 2'd1;
    localparam logic [1:0] OP_FAIL = 2'd2;
    localparam logic [1:0] OP_HALT = 2'd3;

    localparam int RES_SLOTS = 4;

    typedef struct packed {
        logic       last;
        logic [5:0] count;
        logic [2:0] status;
        logic [1:0] kind;
        logic [7:0] data;
    } res_t;

    typedef struct packed {
        res_t [RES_SLOTS-1:0] r;
        logic [2:0]           n;
    } res_bundle_t;

endpackage

`default_nettype wire

// ===== sv/cmdws_parse.sv =====
// parser state, configuration limits and per-byte result generation
`default_nettype none

module cmdws_parse import cmdws_pkg::*; (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire logic        accept,
    input  wire logic [7:0]  in_byte,
    input  wire logic        last_byte,
    output res_bundle_t      bundle
);

    logic [15:0] lim_reg;
    logic [5:0]  wlim_reg;

    logic [1:0]  mode_reg;
    logic [7:0]  oq_reg;
    logic [7:0]  iq_reg;
    logic        iiq_reg;
    logic        esc_reg;
    logic        pp_reg;
    logic        pb_reg;
    logic [3:0]  nest_reg;
    logic [5:0]  words_reg;
    logic [15:0] pos_reg;
    logic [16:0] len_reg;
    logic [2:0]  err_reg;
    logic        stop_reg;

    // working copies of the state during one byte
    logic [1:0]  mode;
    logic [7:0]  oq;
    logic [7:0]  iq;
    logic        iiq;
    logic        esc;
    logic        pp;
    logic        pb;
    logic [3:0]  nest;
    logic [5:0]  words;
    logic        do_word;
    logic        do_open;
    logic        handled;
    logic        is_blank;

    logic [1:0]  op_kind [RES_SLOTS];
    logic [7:0]  op_byte [RES_SLOTS];
    logic [2:0]  op_code [RES_SLOTS];
    logic [2:0]  n_ops;

    logic [RES_SLOTS-1:0] full_at;
    logic        stp;
    logic [2:0]  err;
    logic [2:0]  k;
    logic [2:0]  rn;
    logic [2:0]  st;
    logic [16:0] pos_sum;
    logic [15:0] pos_next;
    logic [16:0] len_next;
    res_t [RES_SLOTS-1:0] res;

    logic [6:0]  mw;
    logic [6:0]  mw_m1;

    assign mw    = cfg_data[6:0];
    assign mw_m1 = mw - 7'd1;

    // limits are stored already derived
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lim_reg  <= LEN_LIMIT_RESET;
            wlim_reg <= WORD_LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_BUF_LEN:
                begin
                    lim_reg <= (cfg_data == 16'd0) ? 16'd0 : cfg_data - 16'd1;
                end
                REG_MAX_WORDS:
                begin
                    if (mw < 7'd2)
                        wlim_reg <= 6'd1;
                    else if (mw_m1 > 7'd63)
                        wlim_reg <= 6'd63;
                    else
                        wlim_reg <= mw_m1[5:0];
                end
            endcase
        end
    end

    assign is_blank = (in_byte == CH_SPACE) || (in_byte == CH_TAB);

    // byte parsing: builds an ordered list of operations
    always_comb
    begin
        mode    = mode_reg;
        oq      = oq_reg;
        iq      = iq_reg;
        iiq     = iiq_reg;
        esc     = esc_reg;
        pp      = pp_reg;
        pb      = pb_reg;
        nest    = nest_reg;
        words   = words_reg;
        do_word = 1'b0;
        do_open = 1'b0;
        handled = 1'b0;
        n_ops   = 3'd0;
        for (int j = 0; j < RES_SLOTS; j++)
        begin
            op_kind[j] = OP_DATA;
            op_byte[j] = 8'd0;
            op_code[j] = ST_OK;
        end

        if (!stop_reg)
        begin
            unique case (mode_reg)
                MODE_IDLE:
                begin
                    if (!is_blank)
                    begin
                        if (words != 6'd63)
                            words = words + 6'd1;
                        if (words >= wlim_reg)
                        begin
                            op_kind[n_ops[1:0]] = OP_HALT;
                            n_ops = n_ops + 3'd1;
                        end
                        else
                        begin
                            mode    = MODE_WORD;
                            do_word = 1'b1;
                        end
                    end
                end
                MODE_WORD:
                begin
                    do_word = 1'b1;
                end
                MODE_QUOTE:
                begin
                    if (esc)
                    begin
                        op_kind[n_ops[1:0]] = OP_DATA;
                        op_byte[n_ops[1:0]] = in_byte;
                        n_ops = n_ops + 3'd1;
                        esc = 1'b0;
                    end
                    else if (in_byte == CH_BSLASH)
                    begin
                        op_kind[n_ops[1:0]] = OP_DATA;
                        op_byte[n_ops[1:0]] = in_byte;
                        n_ops = n_ops + 3'd1;
                        esc = 1'b1;
                    end
                    else if (in_byte == oq)
                    begin
                        mode = MODE_WORD;
                    end
                    else
                    begin
                        op_kind[n_ops[1:0]] = OP_DATA;
                        op_byte[n_ops[1:0]] = in_byte;
                        n_ops = n_ops + 3'd1;
                    end
                end
                MODE_VAR:
                begin
                    if (iiq)
                    begin
                        op_kind[n_ops[1:0]] = OP_DATA;
                        op_byte[n_ops[1:0]] = in_byte;
                        n_ops = n_ops + 3'd1;
                        if (esc)
                            esc = 1'b0;
                        else if (in_byte == CH_BSLASH)
                            esc = 1'b1;
                        else if (in_byte == iq)
                            iiq = 1'b0;
                    end
                    else if (esc)
                    begin
                        op_kind[n_ops[1:0]] = OP_DATA;
                        op_byte[n_ops[1:0]] = in_byte;
                        n_ops = n_ops + 3'd1;
                        esc = 1'b0;
                    end
                    else
                    begin
                        if (pp)
                        begin
                            pp = 1'b0;
                            if (in_byte == CH_LBRACE)
                            begin
                                do_open = 1'b1;
                                handled = 1'b1;
                            end
                            else
                            begin
                                op_kind[n_ops[1:0]] = OP_DATA;
                                op_byte[n_ops[1:0]] = CH_PERCENT;
                                n_ops = n_ops + 3'd1;
                            end
                        end
                        if (!handled)
                        begin
                            priority if (in_byte == CH_DQUOTE || in_byte == CH_SQUOTE)
                            begin
                                op_kind[n_ops[1:0]] = OP_DATA;
                                op_byte[n_ops[1:0]] = in_byte;
                                n_ops = n_ops + 3'd1;
                                iq  = in_byte;
                                iiq = 1'b1;
                            end
                            else if (in_byte == CH_RBRACE)
                            begin
                                op_kind[n_ops[1:0]] = OP_DATA;
                                op_byte[n_ops[1:0]] = in_byte;
                                n_ops = n_ops + 3'd1;
                                if (nest != 4'd0)
                                    nest = nest - 4'd1;
                                if (nest == 4'd0)
                                    mode = MODE_WORD;
                            end
                            else if (in_byte == CH_BSLASH)
                            begin
                                op_kind[n_ops[1:0]] = OP_DATA;
                                op_byte[n_ops[1:0]] = in_byte;
                                n_ops = n_ops + 3'd1;
                                esc = 1'b1;
                            end
                            else if (in_byte == CH_PERCENT)
                            begin
                                pp = 1'b1;
                            end
                            else
                            begin
                                op_kind[n_ops[1:0]] = OP_DATA;
                                op_byte[n_ops[1:0]] = in_byte;
                                n_ops = n_ops + 3'd1;
                            end
                        end
                    end
                end
            endcase

            // ordinary word character, with pending backslash or percent first
            if (do_word)
            begin
                if (pb)
                begin
                    pb = 1'b0;
                    op_kind[n_ops[1:0]] = OP_DATA;
                    if (in_byte == CH_SPACE)
                    begin
                        op_byte[n_ops[1:0]] = CH_SPACE;
                        handled = 1'b1;
                    end
                    else
                    begin
                        op_byte[n_ops[1:0]] = CH_BSLASH;
                    end
                    n_ops = n_ops + 3'd1;
                end
                if (!handled && pp)
                begin
                    pp = 1'b0;
                    if (in_byte == CH_LBRACE)
                    begin
                        do_open = 1'b1;
                        handled = 1'b1;
                    end
                    else
                    begin
                        op_kind[n_ops[1:0]] = OP_DATA;
                        op_byte[n_ops[1:0]] = CH_PERCENT;
                        n_ops = n_ops + 3'd1;
                    end
                end
                if (!handled)
                begin
                    priority if (is_blank)
                    begin
                        op_kind[n_ops[1:0]] = OP_WEND;
                        n_ops = n_ops + 3'd1;
                        mode = MODE_IDLE;
                    end
                    else if (in_byte == CH_DQUOTE || in_byte == CH_SQUOTE)
                    begin
                        oq   = in_byte;
                        mode = MODE_QUOTE;
                    end
                    else if (in_byte == CH_PERCENT)
                    begin
                        pp = 1'b1;
                    end
                    else if (in_byte == CH_BSLASH)
                    begin
                        pb = 1'b1;
                    end
                    else
                    begin
                        op_kind[n_ops[1:0]] = OP_DATA;
                        op_byte[n_ops[1:0]] = in_byte;
                        n_ops = n_ops + 3'd1;
                    end
                end
            end

            // opening a variable level
            if (do_open)
            begin
                if (nest >= MAX_NEST)
                begin
                    op_kind[n_ops[1:0]] = OP_FAIL;
                    op_code[n_ops[1:0]] = ST_TOO_DEEP;
                    n_ops = n_ops + 3'd1;
                end
                else
                begin
                    op_kind[n_ops[1:0]] = OP_DATA;
                    op_byte[n_ops[1:0]] = CH_PERCENT;
                    n_ops = n_ops + 3'd1;
                    op_kind[n_ops[1:0]] = OP_DATA;
                    op_byte[n_ops[1:0]] = CH_LBRACE;
                    n_ops = n_ops + 3'd1;
                    nest = nest + 4'd1;
                    mode = MODE_VAR;
                end
            end

            // end of command: flush pending byte, close the word or fail
            if (last_byte)
            begin
                if (pb || pp)
                begin
                    op_kind[n_ops[1:0]] = OP_DATA;
                    op_byte[n_ops[1:0]] = pb ? CH_BSLASH : CH_PERCENT;
                    n_ops = n_ops + 3'd1;
                end
                unique case (mode)
                    MODE_QUOTE:
                    begin
                        op_kind[n_ops[1:0]] = OP_FAIL;
                        op_code[n_ops[1:0]] = ST_BAD_STRING;
                        n_ops = n_ops + 3'd1;
                    end
                    MODE_VAR:
                    begin
                        op_kind[n_ops[1:0]] = OP_FAIL;
                        op_code[n_ops[1:0]] = ST_BAD_VAR;
                        n_ops = n_ops + 3'd1;
                    end
                    MODE_WORD:
                    begin
                        op_kind[n_ops[1:0]] = OP_WEND;
                        n_ops = n_ops + 3'd1;
                    end
                    MODE_IDLE:
                    begin
                    end
                endcase
            end
        end
    end

    // buffer full flags for each number of positions taken in this byte
    always_comb
    begin
        for (int j = 0; j < RES_SLOTS; j++)
            full_at[j] = ({1'b0, pos_reg} + 17'(j)) >= {1'b0, lim_reg};
    end

    assign len_next = (len_reg == 17'h1FFFF) ? len_reg : len_reg + 17'd1;

    // apply operations in order: space check, first error, stop
    always_comb
    begin
        stp = stop_reg;
        err = err_reg;
        k   = 3'd0;
        rn  = 3'd0;
        st  = ST_OK;
        res = '0;
        for (int j = 0; j < RES_SLOTS; j++)
        begin
            if ((3'(j) < n_ops) && !stp)
            begin
                unique case (op_kind[j])
                    OP_DATA:
                    begin
                        if (full_at[k[1:0]])
                        begin
                            stp = 1'b1;
                            if (err == ST_OK)
                                err = ST_NO_SPACE;
                        end
                        else
                        begin
                            res[rn[1:0]].kind = KIND_DATA;
                            res[rn[1:0]].data = op_byte[j];
                            rn = rn + 3'd1;
                            k  = k + 3'd1;
                        end
                    end
                    OP_WEND:
                    begin
                        res[rn[1:0]].kind = KIND_WEND;
                        rn = rn + 3'd1;
                        k  = k + 3'd1;
                    end
                    OP_FAIL:
                    begin
                        stp = 1'b1;
                        err = op_code[j];
                    end
                    OP_HALT:
                    begin
                        stp = 1'b1;
                    end
                endcase
            end
        end

        priority if (len_next > {1'b0, lim_reg})
            st = ST_TOO_LONG;
        else if (in_byte == CH_BSLASH)
            st = ST_FINAL_BSLASH;
        else if (err != ST_OK)
            st = err;
        else if (words == 6'd0)
            st = ST_EMPTY;
        else
            st = ST_OK;

        if (last_byte)
        begin
            res[rn[1:0]].kind   = KIND_STATUS;
            res[rn[1:0]].status = st;
            res[rn[1:0]].count  = words;
            rn = rn + 3'd1;
        end

        for (int j = 0; j < RES_SLOTS; j++)
            res[j].last = ((3'(j) + 3'd1) == rn);
    end

    assign pos_sum  = {1'b0, pos_reg} + 17'(k);
    assign pos_next = pos_sum[16] ? 16'hFFFF : pos_sum[15:0];

    assign bundle.r = res;
    assign bundle.n = rn;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IDLE;
            oq_reg    <= 8'd0;
            iq_reg    <= 8'd0;
            iiq_reg   <= 1'b0;
            esc_reg   <= 1'b0;
            pp_reg    <= 1'b0;
            pb_reg    <= 1'b0;
            nest_reg  <= 4'd0;
            words_reg <= 6'd0;
            pos_reg   <= 16'd0;
            len_reg   <= 17'd0;
            err_reg   <= ST_OK;
            stop_reg  <= 1'b0;
        end
        else if (accept)
        begin
            if (last_byte)
            begin
                // command done: back to the reset state
                mode_reg  <= MODE_IDLE;
                oq_reg    <= 8'd0;
                iq_reg    <= 8'd0;
                iiq_reg   <= 1'b0;
                esc_reg   <= 1'b0;
                pp_reg    <= 1'b0;
                pb_reg    <= 1'b0;
                nest_reg  <= 4'd0;
                words_reg <= 6'd0;
                pos_reg   <= 16'd0;
                len_reg   <= 17'd0;
                err_reg   <= ST_OK;
                stop_reg  <= 1'b0;
            end
            else
            begin
                mode_reg  <= mode;
                oq_reg    <= oq;
                iq_reg    <= iq;
                iiq_reg   <= iiq;
                esc_reg   <= esc;
                pp_reg    <= pp;
                pb_reg    <= pb;
                nest_reg  <= nest;
                words_reg <= words;
                pos_reg   <= pos_next;
                len_reg   <= len_next;
                err_reg   <= err;
                stop_reg  <= stp;
            end
        end
    end

endmodule

`default_nettype wire

// ===== sv/cmdws_outbuf.sv =====
// result register: holds the words of one byte and hands them out one a cycle while out_ready is high
`default_nettype none

module cmdws_outbuf import cmdws_pkg::*; (
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  load,
    input  wire res_bundle_t bundle,
    input  wire logic  out_ready,
    output logic       out_valid,
    output res_t       out_word,
    output logic       in_ready
);

    res_t [RES_SLOTS-1:0] q_reg;
    logic [2:0] cnt_reg;
    logic [1:0] rd_reg;
    logic       pop;

    assign out_valid = (cnt_reg != 3'd0);
    assign out_word  = q_reg[rd_reg];
    assign pop       = out_valid && out_ready;

    // new byte may enter once the last waiting word leaves this cycle
    assign in_ready = (cnt_reg == 3'd0) || ((cnt_reg == 3'd1) && out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 3'd0;
            rd_reg  <= 2'd0;
        end
        else if (load)
        begin
            cnt_reg <= bundle.n;
            rd_reg  <= 2'd0;
        end
        else if (pop)
        begin
            cnt_reg <= cnt_reg - 3'd1;
            rd_reg  <= rd_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            q_reg <= bundle.r;
    end

endmodule

`default_nettype wire

// ===== sv/command_line_word_splitter_top.sv =====
// Command line word splitter: splits a byte stream into words with a status per command.
//
// Input stream s_*: one command byte per word, s_tlast on the final byte of a command.
// Output stream m_*: data bytes (m_tuser 0), end-of-word marks (1) and one final status
// (2) carrying the word count; m_tlast marks the last word caused by one input byte.
// Configuration: cfg_we with cfg_index 0 writes the buffer length, index 1 the number
// of word slots; write only while no command byte is in flight.
// Latency: the words of an accepted byte appear on m_* in the next cycle.
// Throughput: one byte per cycle while each byte gives at most one word and m_tready is
// high; a byte giving more words (up to four) holds the input until the last of them is
// taken by the single output port that drains the result register one word a cycle.
// A byte may be accepted in the cycle its predecessor's last word is taken, so the
// result register parts the two sides without bubbles.
// Stalls: with m_tready low the waiting words hold and s_tready drops.
// Reset: parser returns to the idle state, limits return to 1024 bytes and 32 slots,
// and any words not yet taken are dropped.
`default_nettype none

module command_line_word_splitter_top import cmdws_pkg::*; (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // in_byte
    input  wire logic        s_tlast,   // last_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // out_byte, status, word_count, zero fill
    output logic [1:0]       m_tuser,   // kind
    output logic             m_tlast    // last
);

    res_bundle_t bundle;
    res_t        word;
    logic        accept;

    assign accept = s_tvalid && s_tready;

    cmdws_parse u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .in_byte   (s_tdata),
        .last_byte (s_tlast),
        .bundle    (bundle)
    );

    cmdws_outbuf u_outbuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept),
        .bundle    (bundle),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_word  (word),
        .in_ready  (s_tready)
    );

    assign m_tdata = {7'd0, word.count, word.status, word.data};
    assign m_tuser = word.kind;
    assign m_tlast = word.last;

    // a final status is always the last word of its byte
    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == KIND_STATUS) |-> m_tlast)
        else $error("status word without last flag");

    // data and end-of-word marks carry no status or count
    a_clean_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser != KIND_STATUS) |-> (m_tdata[16:8] == 9'd0))
        else $error("status or count set on a non-status word");

    // input taken while output waits only when the final waiting word leaves
    a_ready_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tready && m_tvalid) |-> (m_tready && m_tlast))
        else $error("byte accepted while earlier words still wait");

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
// self-checking testbench for the command line word splitter
module tb_top;
    import cmdws_pkg::*;

    typedef struct packed {
        logic [7:0] b;
        logic       lst;
    } cmd_byte_t;

    typedef struct packed {
        logic [7:0] b;
        logic [1:0] k;
        logic [2:0] st;
        logic [5:0] cnt;
        logic       lst;
    } split_word_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_index = 1'b0;
    logic [15:0] cfg_data = 16'd0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'd0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    command_line_word_splitter_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // stimulus, expectations and run statistics
    cmd_byte_t   pending_bytes[$];
    split_word_t expected_words[$];
    split_word_t step_words[$];
    logic [7:0]  cmd_bytes[$];
    logic        in_fire = 1'b0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          idle_mode = 0;
    int          errors = 0;
    int          sent_bytes = 0;
    int          commands_seen = 0;
    int          words_checked = 0;
    logic [7:0]  status_seen = 8'd0;

    // splitter state as predicted
    int          lim_buf = 1024;
    int          lim_words = 32;
    logic [1:0]  ps_mode;
    logic [7:0]  ps_outer_q;
    logic [7:0]  ps_inner_q;
    logic        ps_in_inner;
    logic        ps_escape;
    logic        ps_pct;
    logic        ps_bsl;
    logic        ps_prev_bs;
    logic        ps_stopped;
    logic [2:0]  ps_err;
    int          ps_depth;
    int          ps_words;
    int          ps_pos;
    int          ps_len;

    function automatic void clear_parse();
        ps_mode = MODE_IDLE;
        ps_outer_q = 8'd0;
        ps_inner_q = 8'd0;
        ps_in_inner = 1'b0;
        ps_escape = 1'b0;
        ps_pct = 1'b0;
        ps_bsl = 1'b0;
        ps_prev_bs = 1'b0;
        ps_stopped = 1'b0;
        ps_err = ST_OK;
        ps_depth = 0;
        ps_words = 0;
        ps_pos = 0;
        ps_len = 0;
    endfunction

    function automatic void emit(logic [1:0] k, logic [7:0] b, logic [2:0] st, logic [5:0] cnt);
        split_word_t w;
        if (step_words.size() >= RES_SLOTS)
            return;
        w.b = b;
        w.k = k;
        w.st = st;
        w.cnt = cnt;
        w.lst = 1'b0;
        step_words.push_back(w);
    endfunction

    function automatic int byte_limit();
        return (lim_buf == 0) ? 0 : lim_buf - 1;
    endfunction

    function automatic int word_cap();
        int lim;
        lim = (lim_words >= 2) ? lim_words - 1 : 1;
        return (lim > 63) ? 63 : lim;
    endfunction

    function automatic void note_error(logic [2:0] code);
        if (ps_stopped)
            return;
        if (ps_err == ST_OK)
            ps_err = code;
        ps_stopped = 1'b1;
    endfunction

    // space is checked before every data byte, never before a word end
    function automatic void put_byte(logic [7:0] c);
        if (ps_stopped)
            return;
        if (ps_pos >= byte_limit())
        begin
            note_error(ST_NO_SPACE);
            return;
        end
        emit(KIND_DATA, c, ST_OK, 6'd0);
        ps_pos++;
    endfunction

    function automatic void close_word();
        if (ps_stopped)
            return;
        emit(KIND_WEND, 8'd0, ST_OK, 6'd0);
        if (ps_pos < 16'hFFFF)
            ps_pos++;
    endfunction

    function automatic void open_variable();
        if (ps_stopped)
            return;
        if (ps_depth >= MAX_NEST)
        begin
            note_error(ST_TOO_DEEP);
            return;
        end
        put_byte(CH_PERCENT);
        put_byte(CH_LBRACE);
        ps_depth++;
        ps_mode = MODE_VAR;
    endfunction

    function automatic void word_byte(logic [7:0] c);
        if (ps_bsl)
        begin
            ps_bsl = 1'b0;
            if (c == CH_SPACE)
            begin
                put_byte(CH_SPACE);
                return;
            end
            put_byte(CH_BSLASH);
            if (ps_stopped)
                return;
        end
        if (ps_pct)
        begin
            ps_pct = 1'b0;
            if (c == CH_LBRACE)
            begin
                open_variable();
                return;
            end
            put_byte(CH_PERCENT);
            if (ps_stopped)
                return;
        end
        case (c)
            CH_SPACE, CH_TAB:
            begin
                close_word();
                ps_mode = MODE_IDLE;
            end
            CH_DQUOTE, CH_SQUOTE:
            begin
                ps_outer_q = c;
                ps_mode = MODE_QUOTE;
            end
            CH_PERCENT: ps_pct = 1'b1;
            CH_BSLASH:  ps_bsl = 1'b1;
            default:    put_byte(c);
        endcase
    endfunction

    // inside a variable everything is copied, quotes and braces included
    function automatic void variable_byte(logic [7:0] c);
        if (ps_in_inner)
        begin
            if (ps_escape)
            begin
                put_byte(c);
                ps_escape = 1'b0;
            end
            else if (c == CH_BSLASH)
            begin
                put_byte(c);
                ps_escape = 1'b1;
            end
            else
            begin
                put_byte(c);
                if (c == ps_inner_q)
                    ps_in_inner = 1'b0;
            end
            return;
        end
        if (ps_escape)
        begin
            put_byte(c);
            ps_escape = 1'b0;
            return;
        end
        if (ps_pct)
        begin
            ps_pct = 1'b0;
            if (c == CH_LBRACE)
            begin
                open_variable();
                return;
            end
            put_byte(CH_PERCENT);
            if (ps_stopped)
                return;
        end
        case (c)
            CH_DQUOTE, CH_SQUOTE:
            begin
                put_byte(c);
                ps_inner_q = c;
                ps_in_inner = 1'b1;
            end
            CH_RBRACE:
            begin
                put_byte(c);
                if (ps_depth > 0)
                    ps_depth--;
                if (ps_depth == 0)
                    ps_mode = MODE_WORD;
            end
            CH_BSLASH:
            begin
                put_byte(c);
                ps_escape = 1'b1;
            end
            CH_PERCENT: ps_pct = 1'b1;
            default:    put_byte(c);
        endcase
    endfunction

    function automatic void parse_byte(logic [7:0] c);
        case (ps_mode)
            MODE_IDLE:
            begin
                if (c == CH_SPACE || c == CH_TAB)
                    return;
                if (ps_words < 63)
                    ps_words++;
                // the word that reaches the limit is counted but not emitted
                if (ps_words >= word_cap())
                begin
                    ps_stopped = 1'b1;
                    return;
                end
                ps_mode = MODE_WORD;
                word_byte(c);
            end
            MODE_WORD:
                word_byte(c);
            MODE_QUOTE:
            begin
                if (ps_escape)
                begin
                    put_byte(c);
                    ps_escape = 1'b0;
                end
                else if (c == CH_BSLASH)
                begin
                    put_byte(c);
                    ps_escape = 1'b1;
                end
                else if (c == ps_outer_q)
                    ps_mode = MODE_WORD;
                else
                    put_byte(c);
            end
            default:
                variable_byte(c);
        endcase
    endfunction

    function automatic void close_command();
        logic [2:0] st;
        if (!ps_stopped)
        begin
            if (ps_bsl)
            begin
                ps_bsl = 1'b0;
                put_byte(CH_BSLASH);
            end
            if (ps_pct)
            begin
                ps_pct = 1'b0;
                put_byte(CH_PERCENT);
            end
        end
        if (!ps_stopped)
        begin
            if (ps_mode == MODE_QUOTE)
                note_error(ST_BAD_STRING);
            else if (ps_mode == MODE_VAR)
                note_error(ST_BAD_VAR);
            else if (ps_mode == MODE_WORD)
                close_word();
        end
        if (ps_len > byte_limit())
            st = ST_TOO_LONG;
        else if (ps_prev_bs)
            st = ST_FINAL_BSLASH;
        else if (ps_err != ST_OK)
            st = ps_err;
        else if (ps_words == 0)
            st = ST_EMPTY;
        else
            st = ST_OK;
        emit(KIND_STATUS, 8'd0, st, ps_words[5:0]);
        status_seen[st] = 1'b1;
        commands_seen++;
        clear_parse();
    endfunction

    function automatic void predict_split(logic [7:0] c, logic lst);
        step_words.delete();
        if (ps_len < 'h1FFFF)
            ps_len++;
        ps_prev_bs = (c == CH_BSLASH);
        if (!ps_stopped)
            parse_byte(c);
        if (lst)
            close_command();
        if (step_words.size() > 0)
            step_words[step_words.size() - 1].lst = 1'b1;
        foreach (step_words[i])
            expected_words.push_back(step_words[i]);
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        errors++;
        if (errors <= 50)
            $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
    endtask

    // output check first, then the prediction for a byte taken at the same edge
    always @(posedge clk)
    begin : mon
        split_word_t want;
        in_fire = rst_n && s_tvalid && s_tready;
        if (rst_n && m_tvalid && m_tready)
        begin
            words_checked++;
            if (expected_words.size() == 0)
                report_mismatch("unexpected word, kind", m_tuser, -1);
            else
            begin
                want = expected_words.pop_front();
                if (m_tuser !== want.k)
                    report_mismatch("kind", m_tuser, want.k);
                if (m_tdata[7:0] !== want.b)
                    report_mismatch("out_byte", m_tdata[7:0], want.b);
                if (m_tdata[10:8] !== want.st)
                    report_mismatch("status", m_tdata[10:8], want.st);
                if (m_tdata[16:11] !== want.cnt)
                    report_mismatch("word_count", m_tdata[16:11], want.cnt);
                if (m_tdata[23:17] !== 7'd0)
                    report_mismatch("zero fill", m_tdata[23:17], 0);
                if (m_tlast !== want.lst)
                    report_mismatch("last", m_tlast, want.lst);
            end
        end
        if (in_fire)
            predict_split(s_tdata, s_tlast);
    end

    always @(negedge clk)
    begin : drv
        cmd_byte_t item;
        if (rst_n && (!s_tvalid || in_fire))
        begin
            if (pending_bytes.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                item = pending_bytes.pop_front();
                s_tdata <= item.b;
                s_tlast <= item.lst;
                s_tvalid <= 1'b1;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // one long hold-off when the no-idle phase starts, so the input backs up
    always @(negedge clk)
    begin : rcv
        int  hold_left;
        bit  hold_done;
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else if (rst_n && idle_mode == 2 && !hold_done)
        begin
            hold_done = 1'b1;
            hold_left = 120;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic wait_drained();
        while (pending_bytes.size() != 0 || s_tvalid || expected_words.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, int val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= 16'(val);
        if (idx == REG_BUF_LEN)
            lim_buf = val & 16'hFFFF;
        else
            lim_words = val & 7'h7F;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_idling(int mode);
        idle_mode = mode;
        case (mode)
            0:
            begin
                send_idle_pct = 33;
                recv_idle_pct = 73;
            end
            1:
            begin
                send_idle_pct = 73;
                recv_idle_pct = 33;
            end
            default:
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
        endcase
    endtask

    task automatic add_text(string s);
        for (int i = 0; i < s.len(); i++)
            cmd_bytes.push_back(s[i]);
    endtask

    task automatic send_command();
        cmd_byte_t x;
        for (int i = 0; i < cmd_bytes.size(); i++)
        begin
            x.b = cmd_bytes[i];
            x.lst = (i == cmd_bytes.size() - 1);
            pending_bytes.push_back(x);
            sent_bytes++;
        end
        cmd_bytes.delete();
    endtask

    function automatic logic [7:0] plain_char();
        case ($urandom_range(7))
            0:       return 8'h30 + 8'($urandom_range(9));
            1:       return $urandom_range(1) ? CH_LBRACE : CH_RBRACE;
            default: return 8'h61 + 8'($urandom_range(25));
        endcase
    endfunction

    task automatic add_quoted();
        logic [7:0] q;
        int         n;
        q = $urandom_range(1) ? CH_DQUOTE : CH_SQUOTE;
        n = $urandom_range(4);
        cmd_bytes.push_back(q);
        repeat (n)
        begin
            case ($urandom_range(9))
                0:
                begin
                    cmd_bytes.push_back(CH_BSLASH);
                    cmd_bytes.push_back(8'($urandom_range(255)));
                end
                1:       cmd_bytes.push_back(CH_SPACE);
                2:       cmd_bytes.push_back(q == CH_DQUOTE ? CH_SQUOTE : CH_DQUOTE);
                default: cmd_bytes.push_back(plain_char());
            endcase
        end
        cmd_bytes.push_back(q);
    endtask

    task automatic add_variable(int depth);
        logic [7:0] q;
        for (int i = 0; i < depth; i++)
        begin
            cmd_bytes.push_back(CH_PERCENT);
            cmd_bytes.push_back(CH_LBRACE);
            cmd_bytes.push_back(8'h61 + 8'($urandom_range(25)));
        end
        if ($urandom_range(2) == 0)
        begin
            // a closing brace inside an inner string must not close the level
            q = $urandom_range(1) ? CH_DQUOTE : CH_SQUOTE;
            cmd_bytes.push_back(q);
            cmd_bytes.push_back(CH_RBRACE);
            if ($urandom_range(1))
            begin
                cmd_bytes.push_back(CH_BSLASH);
                cmd_bytes.push_back(q);
            end
            cmd_bytes.push_back(q);
        end
        if ($urandom_range(3) == 0)
        begin
            cmd_bytes.push_back(CH_BSLASH);
            cmd_bytes.push_back(CH_RBRACE);
        end
        for (int i = 0; i < depth; i++)
            cmd_bytes.push_back(CH_RBRACE);
    endtask

    task automatic add_word();
        int pieces;
        int n;
        pieces = 1 + $urandom_range(2);
        repeat (pieces)
        begin
            case ($urandom_range(9))
                4, 5: add_quoted();
                6:    add_variable(($urandom_range(14) == 0) ? 14 + $urandom_range(2)
                                                              : 1 + $urandom_range(1));
                7:
                begin
                    cmd_bytes.push_back(CH_BSLASH);
                    cmd_bytes.push_back(CH_SPACE);
                end
                8:
                begin
                    cmd_bytes.push_back(CH_BSLASH);
                    cmd_bytes.push_back(plain_char());
                end
                9:
                begin
                    cmd_bytes.push_back(CH_PERCENT);
                    cmd_bytes.push_back(plain_char());
                end
                default:
                begin
                    n = 1 + $urandom_range(3);
                    repeat (n) cmd_bytes.push_back(plain_char());
                end
            endcase
        end
    endtask

    task automatic add_gap();
        int n;
        n = 1 + $urandom_range(1);
        repeat (n) cmd_bytes.push_back($urandom_range(1) ? CH_SPACE : CH_TAB);
    endtask

    // mostly well-formed commands, some noise and some broken endings
    task automatic random_command();
        int r;
        int n;
        int keep;
        r = $urandom_range(99);
        if (r < 10)
        begin
            n = 1 + $urandom_range(7);
            repeat (n) cmd_bytes.push_back(8'($urandom_range(255)));
        end
        else
        begin
            if ($urandom_range(3) == 0)
                add_gap();
            n = 1 + $urandom_range(4);
            for (int i = 0; i < n; i++)
            begin
                add_word();
                if (i < n - 1 || $urandom_range(3) == 0)
                    add_gap();
            end
            if (r < 24)
            begin
                case ($urandom_range(3))
                    0:
                    begin
                        cmd_bytes.push_back(CH_SQUOTE);
                        cmd_bytes.push_back(plain_char());
                    end
                    1:   add_text("%{x");
                    2:   cmd_bytes.push_back(CH_BSLASH);
                    default:
                    begin
                        keep = 1 + $urandom_range(cmd_bytes.size() - 1);
                        while (cmd_bytes.size() > keep)
                            void'(cmd_bytes.pop_back());
                    end
                endcase
            end
        end
        send_command();
    endtask

    task automatic run_phase(int buf_bytes, int slots, int mode, int target);
        int start;
        wait_drained();
        write_reg(REG_BUF_LEN, buf_bytes);
        write_reg(REG_MAX_WORDS, slots);
        set_idling(mode);
        start = sent_bytes;
        while (sent_bytes - start < target)
            random_command();
    endtask

    initial
    begin
        clear_parse();
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed commands with the reset limits
        set_idling(0);
        add_text("a\\ b");
        send_command();
        add_text("'x");
        send_command();
        add_text("%{'}");
        send_command();
        add_text(" ");
        send_command();
        add_text("%");
        send_command();
        add_text("q\\");
        send_command();
        cmd_bytes.push_back(8'h00);
        send_command();
        add_text("\t");
        cmd_bytes.push_back(8'hFF);
        send_command();
        add_text("%{%{}}");
        send_command();

        run_phase(2, 2, 0, 40);
        run_phase(12, 4, 0, 60);
        run_phase(65535, 64, 1, 80);
        run_phase(1024, 32, 1, 50);
        run_phase(30, 8, 2, 70);

        wait_drained();
        repeat (10) @(posedge clk);
        if (expected_words.size() != 0)
            report_mismatch("words never delivered", 0, expected_words.size());
        $display("ran %0d command bytes in %0d commands across six limit settings, %0d words out",
                 sent_bytes, commands_seen, words_checked);
        $display("status codes reached, one bit per code from ok upwards: %b", status_seen);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("timeout with %0d words still expected", expected_words.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== files.f =====
sv/cmdws_pkg.sv
sv/cmdws_parse.sv
sv/cmdws_outbuf.sv
sv/command_line_word_splitter_top.sv
bench/tb_top.sv
